### rtl/rbcv_pkg.sv
// ----------------------------------------------------------------------------
// rbcv_pkg: shared types and constants of the RGB box classifier
// Threshold tables on squared pulse widths, class codes and band flags.
// ----------------------------------------------------------------------------
package rbcv_pkg;

    localparam int PULSE_BITS      = 12;
    localparam int SPV_BITS        = 4;
    localparam int VOTE_BITS       = 4;
    localparam int NUM_CLASSES     = 4;
    localparam int THR_BITS        = 12;
    localparam int NUM_LO          = 5;
    localparam int NUM_HI          = 5;

    localparam logic [SPV_BITS-1:0] SPV_RESET = 4'd10;

    typedef logic [THR_BITS-1:0] thr_t;
    typedef logic [VOTE_BITS-1:0] vote_t;
    typedef logic [SPV_BITS-1:0] spv_t;

    // Scaled value v = floor(p*p/100): v > lo  <=>  p*p >= 100*(lo+1)
    localparam int LO_1  = 0;
    localparam int LO_5  = 1;
    localparam int LO_10 = 2;
    localparam int LO_15 = 3;
    localparam int LO_20 = 4;
    localparam thr_t LO_SQ [NUM_LO] = '{12'd200, 12'd600, 12'd1100, 12'd1600, 12'd2100};

    // v < hi  <=>  p*p < 100*hi
    localparam int HI_15 = 0;
    localparam int HI_20 = 1;
    localparam int HI_25 = 2;
    localparam int HI_30 = 3;
    localparam int HI_35 = 4;
    localparam thr_t HI_SQ [NUM_HI] = '{12'd1500, 12'd2000, 12'd2500, 12'd3000, 12'd3500};

    typedef enum logic [1:0] {
        COLOR_RED    = 2'd0,
        COLOR_GREEN  = 2'd1,
        COLOR_YELLOW = 2'd2,
        COLOR_ORANGE = 2'd3
    } color_t;

    typedef struct packed {
        logic [NUM_LO-1:0] gt;
        logic [NUM_HI-1:0] lt;
    } band_t;

endpackage

### rtl/rbcv_sample_if.sv
// ----------------------------------------------------------------------------
// rbcv_sample_if: sample channel
// Valid/ready channel carrying the three filter pulse widths.
// ----------------------------------------------------------------------------
interface rbcv_sample_if #(
    parameter int PULSE_BITS = rbcv_pkg::PULSE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PULSE_BITS-1:0] red_pulse;
    logic [PULSE_BITS-1:0] green_pulse;
    logic [PULSE_BITS-1:0] blue_pulse;

    modport source (output valid, red_pulse, green_pulse, blue_pulse, input ready);
    modport sink   (input valid, red_pulse, green_pulse, blue_pulse, output ready);
endinterface

### rtl/rbcv_result_if.sv
// ----------------------------------------------------------------------------
// rbcv_result_if: result channel
// Valid/ready channel carrying the winning color code.
// ----------------------------------------------------------------------------
interface rbcv_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] color_code;

    modport source (output valid, color_code, input ready);
    modport sink   (input valid, color_code, output ready);
endinterface

### rtl/rbcv_cfg_if.sv
// ----------------------------------------------------------------------------
// rbcv_cfg_if: configuration write channel
// Valid/ready channel carrying the burst length register value.
// ----------------------------------------------------------------------------
interface rbcv_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rbcv_pkg::SPV_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/rbcv_lane.sv
// ----------------------------------------------------------------------------
// rbcv_lane: one color channel lane
// Squares a pulse width into a register, then flags it against the bounds.
// ----------------------------------------------------------------------------
module rbcv_lane #(
    parameter int PULSE_BITS = rbcv_pkg::PULSE_BITS
) (
    input  logic                  clk,
    input  logic                  advance,
    input  logic [PULSE_BITS-1:0] pulse,
    output rbcv_pkg::band_t       band
);

    localparam int SQ_W  = 2 * PULSE_BITS;
    localparam int CMP_W = (SQ_W > rbcv_pkg::THR_BITS) ? SQ_W : rbcv_pkg::THR_BITS;

    logic [SQ_W-1:0]  square_reg;
    logic [SQ_W-1:0]  square_next;
    logic [CMP_W-1:0] square_ext;

    assign square_next = SQ_W'(pulse) * SQ_W'(pulse);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            square_reg <= square_next;
        end
    end

    assign square_ext = CMP_W'(square_reg);

    always_comb
    begin
        for (int i = 0; i < rbcv_pkg::NUM_LO; i++)
        begin
            band.gt[i] = square_ext >= CMP_W'(rbcv_pkg::LO_SQ[i]);
        end
        for (int i = 0; i < rbcv_pkg::NUM_HI; i++)
        begin
            band.lt[i] = square_ext < CMP_W'(rbcv_pkg::HI_SQ[i]);
        end
    end

endmodule

### rtl/rbcv_vote.sv
// ----------------------------------------------------------------------------
// rbcv_vote: box match, vote counters and burst winner
// Merges the three lane flags into a class, counts votes, emits the leader.
// ----------------------------------------------------------------------------
module rbcv_vote (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 item_valid,
    input  rbcv_pkg::band_t      red_band,
    input  rbcv_pkg::band_t      green_band,
    input  rbcv_pkg::band_t      blue_band,
    input  rbcv_pkg::spv_t       samples_per_vote,
    output logic                 out_valid,
    output logic [1:0]           out_code
);

    localparam int NC = rbcv_pkg::NUM_CLASSES;

    rbcv_pkg::vote_t vote_reg  [NC];
    rbcv_pkg::vote_t vote_next [NC];
    rbcv_pkg::spv_t  count_reg;
    rbcv_pkg::spv_t  count_next;
    logic            valid_reg;
    logic            valid_next;
    logic [1:0]      code_reg;
    logic [1:0]      code_next;

    logic [NC-1:0]   hit;
    logic [NC-1:0]   sel;
    rbcv_pkg::vote_t vote_inc [NC];
    logic [NC-1:0]   leads;
    rbcv_pkg::spv_t  limit;
    logic            end_burst;
    logic            any_lead;
    logic [1:0]      winner;

    always_comb
    begin
        hit[rbcv_pkg::COLOR_RED] =
            red_band.gt[rbcv_pkg::LO_5]    & red_band.lt[rbcv_pkg::HI_15] &
            green_band.gt[rbcv_pkg::LO_20] & green_band.lt[rbcv_pkg::HI_35] &
            blue_band.gt[rbcv_pkg::LO_15]  & blue_band.lt[rbcv_pkg::HI_30];
        hit[rbcv_pkg::COLOR_GREEN] =
            red_band.gt[rbcv_pkg::LO_10]   & red_band.lt[rbcv_pkg::HI_20] &
            green_band.gt[rbcv_pkg::LO_10] & green_band.lt[rbcv_pkg::HI_25] &
            blue_band.gt[rbcv_pkg::LO_15]  & blue_band.lt[rbcv_pkg::HI_25];
        hit[rbcv_pkg::COLOR_YELLOW] =
            red_band.gt[rbcv_pkg::LO_1]    & red_band.lt[rbcv_pkg::HI_15] &
            green_band.gt[rbcv_pkg::LO_5]  & green_band.lt[rbcv_pkg::HI_20] &
            blue_band.gt[rbcv_pkg::LO_10]  & blue_band.lt[rbcv_pkg::HI_25];
        hit[rbcv_pkg::COLOR_ORANGE] =
            red_band.gt[rbcv_pkg::LO_1]    & red_band.lt[rbcv_pkg::HI_15] &
            green_band.gt[rbcv_pkg::LO_15] & green_band.lt[rbcv_pkg::HI_30] &
            blue_band.gt[rbcv_pkg::LO_15]  & blue_band.lt[rbcv_pkg::HI_25];
    end

    // first matching box wins
    assign sel = hit & ~(hit - NC'(1)) ;

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            vote_inc[k] = vote_reg[k] + rbcv_pkg::VOTE_BITS'(sel[k]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            leads[k] = 1'b1;
            for (int j = 0; j < NC; j++)
            begin
                if (j != k && vote_inc[k] <= vote_inc[j])
                begin
                    leads[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        winner = 2'(rbcv_pkg::COLOR_RED);
        for (int k = NC - 1; k >= 0; k--)
        begin
            if (leads[k])
            begin
                winner = 2'(k);
            end
        end
    end

    assign any_lead  = |leads;
    assign limit     = (samples_per_vote == '0) ? rbcv_pkg::SPV_BITS'(1) : samples_per_vote;
    assign end_burst = ({1'b0, count_reg} + 5'd1) >= {1'b0, limit};

    always_comb
    begin
        vote_next  = vote_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        code_next  = code_reg;
        if (advance)
        begin
            valid_next = 1'b0;
            if (item_valid)
            begin
                if (end_burst)
                begin
                    for (int k = 0; k < NC; k++)
                    begin
                        vote_next[k] = '0;
                    end
                    count_next = '0;
                    valid_next = any_lead;
                    code_next  = winner;
                end
                else
                begin
                    vote_next  = vote_inc;
                    count_next = count_reg + rbcv_pkg::SPV_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NC; k++)
            begin
                vote_reg[k] <= '0;
            end
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            vote_reg  <= vote_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;

endmodule

### rtl/rgb_box_classifier_vote.sv
// ----------------------------------------------------------------------------
// rgb_box_classifier_vote: three-filter color box classifier with voting
// Usage:
//   sample: valid/ready channel of red, green and blue pulse widths.
//   cfg:    write channel for the burst length; always ready.
//   result: valid/ready channel of the winning color code.
// One sample is taken per cycle unless result stalls. Three lanes square
// the pulse widths in parallel into a register; rbcv_vote then flags
// them against the box bounds, updates the vote counters and loads the
// result register. A burst that ends in a tie gives no result.
// When result is stalled, the sample pipeline holds and sample.ready drops;
// while the result register is free or taken, a new sample enters every
// cycle.
// Reset clears the votes, the sample count and the pipeline valids and
// loads a burst length of ten.
// ----------------------------------------------------------------------------
module rgb_box_classifier_vote #(
    parameter int PULSE_BITS = rbcv_pkg::PULSE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    rbcv_sample_if.sink sample,
    rbcv_cfg_if.sink    cfg,
    rbcv_result_if.source result
);

    logic            advance;
    logic            s1_valid_reg;
    logic            s1_valid_next;
    rbcv_pkg::spv_t  spv_reg;
    rbcv_pkg::spv_t  spv_next;
    rbcv_pkg::band_t red_band;
    rbcv_pkg::band_t green_band;
    rbcv_pkg::band_t blue_band;

    assign advance      = !result.valid || result.ready;
    assign sample.ready = advance;
    assign cfg.ready    = 1'b1;

    assign s1_valid_next = advance ? sample.valid : s1_valid_reg;
    assign spv_next      = cfg.valid ? cfg.data : spv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            spv_reg      <= rbcv_pkg::SPV_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            spv_reg      <= spv_next;
        end
    end

    rbcv_lane #(.PULSE_BITS(PULSE_BITS)) u_lane_red (
        .clk     (clk),
        .advance (advance),
        .pulse   (sample.red_pulse),
        .band    (red_band)
    );

    rbcv_lane #(.PULSE_BITS(PULSE_BITS)) u_lane_green (
        .clk     (clk),
        .advance (advance),
        .pulse   (sample.green_pulse),
        .band    (green_band)
    );

    rbcv_lane #(.PULSE_BITS(PULSE_BITS)) u_lane_blue (
        .clk     (clk),
        .advance (advance),
        .pulse   (sample.blue_pulse),
        .band    (blue_band)
    );

    rbcv_vote u_vote (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .item_valid       (s1_valid_reg),
        .red_band         (red_band),
        .green_band       (green_band),
        .blue_band        (blue_band),
        .samples_per_vote (spv_reg),
        .out_valid        (result.valid),
        .out_code         (result.color_code)
    );

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RGB box classifier with burst voting
// Drives pulse-width samples and burst lengths over the valid/ready channels,
// predicts the winning color of every burst from the squared, scaled widths
// and the four box bounds, and checks each result transfer in order.
// Stalls and gaps of random length fall on both the sample and result sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          PB            = rbcv_pkg::PULSE_BITS;
    localparam int          NO_BOX        = rbcv_pkg::NUM_CLASSES;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          RANDOM_ITEMS  = 930;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef logic [PB-1:0] pulse_t;

    // Exclusive bounds on the scaled widths, per class, per filter (red, green, blue)
    localparam int unsigned BOX_LO [rbcv_pkg::NUM_CLASSES][3] =
        '{'{5, 20, 15}, '{10, 10, 15}, '{1, 5, 10}, '{1, 15, 15}};
    localparam int unsigned BOX_HI [rbcv_pkg::NUM_CLASSES][3] =
        '{'{15, 35, 30}, '{20, 25, 25}, '{15, 20, 25}, '{15, 30, 25}};

    class vote_tracker;
        rbcv_pkg::spv_t   burst_len;
        rbcv_pkg::vote_t  tally [rbcv_pkg::NUM_CLASSES];
        rbcv_pkg::spv_t   taken;
        rbcv_pkg::color_t expected_colors [$];
        int               errors;

        function new();
            burst_len = rbcv_pkg::SPV_RESET;
            errors    = 0;
            clear_burst();
        endfunction

        function void clear_burst();
            foreach (tally[i])
                tally[i] = '0;
            taken = '0;
        endfunction

        function void set_burst_len(rbcv_pkg::spv_t len);
            burst_len = len;
        endfunction

        function int unsigned scaled(pulse_t p);
            int unsigned w;
            w = p;
            return (w * w) / 100;
        endfunction

        function int box_of(pulse_t r, pulse_t g, pulse_t b);
            int unsigned v [3];
            v[0] = scaled(r);
            v[1] = scaled(g);
            v[2] = scaled(b);
            for (int c = 0; c < rbcv_pkg::NUM_CLASSES; c++)
            begin
                bit hit;
                hit = 1'b1;
                for (int ch = 0; ch < 3; ch++)
                    if (!(v[ch] > BOX_LO[c][ch] && v[ch] < BOX_HI[c][ch]))
                        hit = 1'b0;
                if (hit)
                    return c;
            end
            return NO_BOX;
        endfunction

        function void take_sample(pulse_t r, pulse_t g, pulse_t b);
            int cls;
            int lim;
            int lead;
            cls = box_of(r, g, b);
            if (cls != NO_BOX)
                tally[cls] = tally[cls] + 1'b1;
            lim = (burst_len == '0) ? 1 : int'(burst_len);
            if (int'(taken) + 1 < lim)
            begin
                taken = taken + 1'b1;
                return;
            end
            lead = -1;
            for (int k = 0; k < rbcv_pkg::NUM_CLASSES && lead < 0; k++)
            begin
                bit ahead;
                ahead = 1'b1;
                for (int j = 0; j < rbcv_pkg::NUM_CLASSES; j++)
                    if (j != k && tally[k] <= tally[j])
                        ahead = 1'b0;
                if (ahead)
                    lead = k;
            end
            clear_burst();
            if (lead >= 0)
                expected_colors.push_back(rbcv_pkg::color_t'(lead));
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_color(logic [1:0] got);
            rbcv_pkg::color_t want;
            if (expected_colors.size() == 0)
            begin
                flag($sformatf("unexpected color_code %0d with nothing pending", got));
                return;
            end
            want = expected_colors.pop_front();
            if (got !== want)
                flag($sformatf("color_code mismatch: expected %0d (%s) got %0d",
                               want, want.name(), got));
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction

        function void close_out();
            if (expected_colors.size() != 0)
                flag($sformatf("%0d colors never transferred", expected_colors.size()));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycle_count = 0;
    bit          src_steady;
    int          stall_pct;
    vote_tracker tracker = new();

    rbcv_sample_if #(.PULSE_BITS(PB)) sample_ch();
    rbcv_cfg_if                       cfg_ch();
    rbcv_result_if                    result_ch();

    rgb_box_classifier_vote #(.PULSE_BITS(PB)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            tracker.check_color(result_ch.color_code);

    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct)
            begin
                result_ch.ready <= 1'b0;
                stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 8)
                                                          : $urandom_range(2, 0);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic pulse_t pulse_between(int unsigned lo, int unsigned hi);
        int unsigned pmin;
        int unsigned pmax;
        pmin = 0;
        while ((pmin * pmin) / 100 <= lo)
            pmin++;
        pmax = pmin;
        while (((pmax + 1) * (pmax + 1)) / 100 < hi)
            pmax++;
        return pulse_t'($urandom_range(pmax, pmin));
    endfunction

    function automatic int sender_gap();
        int pick;
        if (src_steady)
            return 0;
        pick = $urandom_range(99, 0);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic push_sample(pulse_t r, pulse_t g, pulse_t b);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.red_pulse   <= r;
        sample_ch.green_pulse <= g;
        sample_ch.blue_pulse  <= b;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.take_sample(r, g, b);
    endtask

    task automatic send_box(int cls);
        push_sample(pulse_between(BOX_LO[cls][0], BOX_HI[cls][0]),
                    pulse_between(BOX_LO[cls][1], BOX_HI[cls][1]),
                    pulse_between(BOX_LO[cls][2], BOX_HI[cls][2]));
    endtask

    task automatic send_mixed(int lead);
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 65)
            send_box(lead);
        else if (pick < 80)
            send_box($urandom_range(rbcv_pkg::NUM_CLASSES - 1, 0));
        else if (pick < 93)
            push_sample(pulse_t'($urandom_range(63, 0)), pulse_t'($urandom_range(63, 0)),
                        pulse_t'($urandom_range(63, 0)));
        else
            push_sample(pulse_t'($urandom), pulse_t'($urandom), pulse_t'($urandom));
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_burst_len(rbcv_pkg::spv_t len);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= len;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        tracker.set_burst_len(len);
    endtask

    initial
    begin
        int             sent;
        int             phase;
        int             bursts;
        int             lead;
        rbcv_pkg::spv_t len;

        rst_n                  <= 1'b0;
        sample_ch.valid        <= 1'b0;
        sample_ch.red_pulse    <= '0;
        sample_ch.green_pulse  <= '0;
        sample_ch.blue_pulse   <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.data            <= '0;
        src_steady             = 1'b0;
        stall_pct              = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset burst length of ten, red leads, widths at both extremes
        send_box(rbcv_pkg::COLOR_RED);
        send_box(rbcv_pkg::COLOR_RED);
        send_box(rbcv_pkg::COLOR_RED);
        send_box(rbcv_pkg::COLOR_GREEN);
        send_box(rbcv_pkg::COLOR_GREEN);
        send_box(rbcv_pkg::COLOR_YELLOW);
        send_box(rbcv_pkg::COLOR_ORANGE);
        push_sample('0, '0, '0);
        push_sample('1, '1, '1);
        push_sample('1, '0, '1);
        drain();

        write_burst_len(4'd1);
        send_box(rbcv_pkg::COLOR_GREEN);
        send_box(rbcv_pkg::COLOR_YELLOW);
        send_box(rbcv_pkg::COLOR_ORANGE);
        push_sample('0, '1, '0);
        send_box(rbcv_pkg::COLOR_RED);
        drain();

        // two-way tie gives nothing
        write_burst_len(4'd2);
        send_box(rbcv_pkg::COLOR_RED);
        send_box(rbcv_pkg::COLOR_GREEN);
        drain();

        // length zero acts as one
        write_burst_len(4'd0);
        send_box(rbcv_pkg::COLOR_YELLOW);
        drain();

        // lower the length mid-burst
        write_burst_len(4'd4);
        send_box(rbcv_pkg::COLOR_ORANGE);
        send_box(rbcv_pkg::COLOR_ORANGE);
        send_box(rbcv_pkg::COLOR_RED);
        drain();
        write_burst_len(4'd2);
        send_box(rbcv_pkg::COLOR_ORANGE);
        drain();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == 0)
                len = 4'd15;
            else if (phase == 1)
                len = 4'd1;
            else
                len = rbcv_pkg::spv_t'($urandom_range(15, 0));
            src_steady = (phase % 4 == 2);
            stall_pct  = (phase % 3 == 0) ? 0 : $urandom_range(40, 10);
            write_burst_len(len);
            bursts = $urandom_range(6, 2);
            repeat (bursts)
            begin
                lead = $urandom_range(rbcv_pkg::NUM_CLASSES - 1, 0);
                repeat ((len == '0) ? 1 : int'(len))
                begin
                    send_mixed(lead);
                    sent++;
                end
            end
            drain();
            phase++;
        end

        stall_pct = 0;
        drain();
        tracker.close_out();
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### filelist.f
rtl/rbcv_pkg.sv
rtl/rbcv_sample_if.sv
rtl/rbcv_result_if.sv
rtl/rbcv_cfg_if.sv
rtl/rbcv_lane.sv
rtl/rbcv_vote.sv
rtl/rgb_box_classifier_vote.sv
tb/sv/tb_top.sv
